### rtl/core/lruc_pkg.sv
// Shared types and constants for the LRU key-value cache core.
// Used by lru_key_value_cache_core; has no dependencies of its own.
package lruc_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 16;
  localparam int unsigned KEY_W           = 32;
  localparam int unsigned VAL_W           = 32;
  localparam int unsigned CAP_W           = 5;
  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } action_e;

  typedef struct packed {
    action_e                  action;
    logic signed [KEY_W-1:0]  key;
    logic signed [VAL_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [VAL_W-1:0]  read_value;
  } rsp_t;

endpackage

### rtl/core/lruc_ram.sv
// Simple dual-port synchronous RAM holding the cache entries.
// One write and one registered read per cycle; no package dependencies.
module lruc_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key-value cache.
// Depends on lruc_pkg for the request and response types and on lruc_ram for storage.
//
// An item is taken when start is high and busy is low; busy then stays high until the
// item is finished. Keys, values and recency ranks live in one RAM with a registered read,
// so every item walks all ENTRIES entries through that single read port: a search pass
// and a decision state, followed for a hit or a put by a read-modify-write pass. A get
// that misses returns to idle after the decision state; any other item goes on to the
// read-modify-write pass. A get produces its result on rsp_o for exactly one cycle with
// rsp_strobe_o high, in the cycle after the decision cycle; the receiver cannot hold it
// off, and a put produces no transfer. Capacity writes are taken at any edge with
// cfg_we_i high and should be made while idle.
module lru_key_value_cache_core #(
  parameter int unsigned ENTRIES = lruc_pkg::ENTRIES_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  lruc_pkg::req_t           req_i,
  output logic                     rsp_strobe_o,
  output lruc_pkg::rsp_t           rsp_o,
  input  logic                     cfg_we_i,
  input  logic [lruc_pkg::CAP_W-1:0] cfg_wdata_i
);

  import lruc_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  typedef struct packed {
    logic [IDX_W-1:0] rank;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [IDX_W-1:0]   pos_q;
  req_t               req_q;
  logic               found_q;
  logic [IDX_W-1:0]   match_q;
  logic [IDX_W-1:0]   mrank_q;
  logic [VAL_W-1:0]   hval_q;
  logic               slot_found_q;
  logic [IDX_W-1:0]   slot_q;
  logic               evict_q;
  logic [CNT_W-1:0]   occ_q;
  logic [CAP_W-1:0]   cap_q;
  logic [ENTRIES-1:0] valid_q;
  logic               rsp_strobe_q;
  rsp_t               rsp_q;

  logic [CNT_W-1:0]   cap_eff;
  logic [CNT_W-1:0]   thr;
  logic               proc;
  logic               last;
  logic [IDX_W-1:0]   rd_addr;
  logic [$bits(entry_t)-1:0] rd_data;
  entry_t             rd_ent;
  logic               ent_valid;
  logic               aged;
  logic               scan_match;
  logic               scan_free;
  logic               is_put;
  logic               insert;
  logic               mem_we;
  entry_t             wr_ent;
  logic               vset;
  logic               vclr;

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(cap_q) > int'(ENTRIES)) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(cap_q);
    end
  end

  assign thr        = cap_eff - CNT_W'(1);
  assign proc       = (cnt_q != '0);
  assign last       = (cnt_q == CNT_W'(ENTRIES));
  assign rd_addr    = last ? '0 : cnt_q[IDX_W-1:0];
  assign rd_ent     = entry_t'(rd_data);
  assign ent_valid  = valid_q[pos_q];
  assign aged       = ent_valid && evict_q && (CNT_W'(rd_ent.rank) >= thr);
  assign scan_match = ent_valid && (rd_ent.key == req_q.key);
  assign scan_free  = !ent_valid || aged;
  assign is_put     = (req_q.action == ACT_PUT);
  assign insert     = is_put && !found_q;

  always_comb begin
    mem_we = 1'b0;
    wr_ent = rd_ent;
    vset   = 1'b0;
    vclr   = 1'b0;
    if ((state_q == ST_UPDATE) && proc) begin
      if (found_q) begin
        if (ent_valid) begin
          mem_we = 1'b1;
          if (pos_q == match_q) begin
            wr_ent.rank = '0;
            if (is_put) begin
              wr_ent.value = req_q.value;
            end
          end else if (rd_ent.rank < mrank_q) begin
            wr_ent.rank = rd_ent.rank + IDX_W'(1);
          end
        end
      end else if (pos_q == slot_q) begin
        mem_we       = 1'b1;
        wr_ent.rank  = '0;
        wr_ent.key   = req_q.key;
        wr_ent.value = req_q.value;
        vset         = 1'b1;
      end else if (ent_valid) begin
        if (aged) begin
          vclr = 1'b1;
        end else begin
          mem_we      = 1'b1;
          wr_ent.rank = rd_ent.rank + IDX_W'(1);
        end
      end
    end
  end

  lruc_ram #(
    .DEPTH (ENTRIES),
    .WIDTH ($bits(entry_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (pos_q),
    .wdata_i (wr_ent),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && start) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      pos_q        <= '0;
      found_q      <= 1'b0;
      match_q      <= '0;
      mrank_q      <= '0;
      hval_q       <= '0;
      slot_found_q <= 1'b0;
      slot_q       <= '0;
      evict_q      <= 1'b0;
      occ_q        <= '0;
      cap_q        <= CAP_RESET;
      valid_q      <= '0;
      rsp_strobe_q <= 1'b0;
      rsp_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      rsp_strobe_q <= 1'b0;
      pos_q        <= cnt_q[IDX_W-1:0];
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q      <= ST_SCAN;
            cnt_q        <= '0;
            found_q      <= 1'b0;
            slot_found_q <= 1'b0;
            evict_q      <= (req_i.action == ACT_PUT) && (occ_q >= cap_eff);
          end
        end
        ST_SCAN: begin
          if (proc) begin
            if (scan_match && !found_q) begin
              found_q <= 1'b1;
              match_q <= pos_q;
              mrank_q <= rd_ent.rank;
              hval_q  <= rd_ent.value;
            end
            if (scan_free && !slot_found_q) begin
              slot_found_q <= 1'b1;
              slot_q       <= pos_q;
            end
          end
          if (last) begin
            state_q <= ST_DECIDE;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_DECIDE: begin
          cnt_q <= '0;
          if (!is_put) begin
            rsp_strobe_q     <= 1'b1;
            rsp_q.hit        <= found_q;
            rsp_q.read_value <= found_q ? hval_q : '0;
          end
          if (!is_put && !found_q) begin
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (vset) begin
            valid_q[pos_q] <= 1'b1;
          end
          if (vclr) begin
            valid_q[pos_q] <= 1'b0;
          end
          if (last) begin
            state_q <= ST_IDLE;
            cnt_q   <= '0;
            if (insert) begin
              occ_q <= evict_q ? cap_eff : (occ_q + CNT_W'(1));
            end
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign rsp_strobe_o = rsp_strobe_q;
  assign rsp_o        = rsp_q;

`ifndef NO_ASSERTIONS
  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ($countones(valid_q) == int'(occ_q)))
    else $error("Occupancy does not match the number of valid entries.");

  a_scan_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !mem_we)
    else $error("Entry RAM written during the search pass.");

  a_insert_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_UPDATE) && insert) |-> slot_found_q)
    else $error("Insert reached the update pass without a free slot.");

  a_rsp_single_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_strobe_q |=> !rsp_strobe_q)
    else $error("Result transfer held for more than one cycle.");

  a_rsp_only_for_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_strobe_q |-> (req_q.action == ACT_GET))
    else $error("Result transfer issued for a put.");
`endif

endmodule

### tb/tb_lru_key_value_cache_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for lru_key_value_cache_core: puts and gets are checked against
// an LRU cache model kept in the bench, over several capacity settings and sender duty cycles.
// Depends on lruc_pkg and lru_key_value_cache_core only.
module tb_lru_key_value_cache_core;
  import lruc_pkg::*;

  localparam int unsigned SLOTS       = ENTRIES_DEFAULT;
  localparam int unsigned RANK_W      = $clog2(SLOTS);
  localparam int unsigned SETTLE      = 2 * SLOTS + 8;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned POOL_SIZE   = 24;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 106;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  req_t             req_i = '0;
  logic             rsp_strobe_o;
  rsp_t             rsp_o;
  logic             cfg_we_i = 1'b0;
  logic [CAP_W-1:0] cfg_wdata_i = '0;

  req_t        pending_reqs[$];
  rsp_t        lookup_results[$];
  int unsigned sender_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  int unsigned      phase_idle[PHASES] = '{0, 84, 7, 0, 84, 7, 0, 84};
  logic [CAP_W-1:0] phase_cap[PHASES]  = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd16, 5'd17, 5'd9};

  logic              line_valid[SLOTS];
  logic [KEY_W-1:0]  line_key[SLOTS];
  logic [VAL_W-1:0]  line_value[SLOTS];
  logic [RANK_W-1:0] line_rank[SLOTS];
  logic [CAP_W-1:0]  line_count;
  logic [CAP_W-1:0]  cap_setting;
  logic [KEY_W-1:0]  key_pool[POOL_SIZE];

  lru_key_value_cache_core #(
    .ENTRIES(SLOTS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_strobe_o(rsp_strobe_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic void make_most_recent(int idx);
    logic [RANK_W-1:0] r;
    r = line_rank[idx];
    for (int j = 0; j < SLOTS; j++) begin
      if (line_valid[j] && line_rank[j] < r) line_rank[j]++;
    end
    line_rank[idx] = '0;
  endfunction

  function automatic void update_cache_model(req_t r);
    int   hit_idx;
    int   free_idx;
    int   victim;
    int   room;
    rsp_t res;
    hit_idx = -1;
    for (int j = 0; j < SLOTS; j++) begin
      if (hit_idx < 0 && line_valid[j] && line_key[j] == r.key) hit_idx = j;
    end
    if (r.action == ACT_PUT) begin
      if (hit_idx >= 0) begin
        line_value[hit_idx] = r.value;
        make_most_recent(hit_idx);
      end else begin
        room = (cap_setting == 0) ? 1 : (cap_setting > SLOTS) ? SLOTS : int'(cap_setting);
        victim = 0;
        while (line_count >= room && victim >= 0) begin
          victim = -1;
          for (int j = 0; j < SLOTS; j++) begin
            if (victim < 0 && line_valid[j] && line_rank[j] == line_count - 1) victim = j;
          end
          if (victim >= 0) begin
            line_valid[victim] = 1'b0;
            line_count--;
          end
        end
        free_idx = -1;
        for (int j = 0; j < SLOTS; j++) begin
          if (free_idx < 0 && !line_valid[j]) free_idx = j;
        end
        if (free_idx >= 0) begin
          for (int j = 0; j < SLOTS; j++) begin
            if (line_valid[j]) line_rank[j]++;
          end
          line_valid[free_idx] = 1'b1;
          line_key[free_idx]   = r.key;
          line_value[free_idx] = r.value;
          line_rank[free_idx]  = '0;
          line_count++;
        end
      end
    end else begin
      res.hit        = (hit_idx >= 0);
      res.read_value = (hit_idx >= 0) ? line_value[hit_idx] : '0;
      lookup_results = {lookup_results, res};
      if (hit_idx >= 0) make_most_recent(hit_idx);
    end
  endfunction

  function automatic void note_mismatch(string what, logic [VAL_W-1:0] want,
                                        logic [VAL_W-1:0] got);
    if (mismatch_count < 10) begin
      $display("Mismatch in %s: expected %h, got %h", what, want, got);
    end
    mismatch_count++;
  endfunction

  function automatic void queue_req(action_e act, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    req_t r;
    r.action = act;
    r.key    = k;
    r.value  = v;
    pending_reqs = {pending_reqs, r};
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || start || lookup_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive_proc
    logic free;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      free = !start || !busy;
      if (start && !busy) update_cache_model(req_i);
      if (free) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          start <= 1'b1;
          req_i <= pending_reqs[0];
          pending_reqs.delete(0);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_proc
    rsp_t want;
    if (rst_ni && rsp_strobe_o) begin
      if (lookup_results.size() == 0) begin
        note_mismatch("unexpected transfer, read_value", '0, rsp_o.read_value);
      end else begin
        want = lookup_results[0];
        lookup_results.delete(0);
        if (rsp_o.hit !== want.hit) begin
          note_mismatch("hit", VAL_W'(want.hit), VAL_W'(rsp_o.hit));
        end
        if (rsp_o.read_value !== want.read_value) begin
          note_mismatch("read_value", want.read_value, rsp_o.read_value);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || rsp_strobe_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int j = 0; j < SLOTS; j++) begin
      line_valid[j] = 1'b0;
      line_key[j]   = '0;
      line_value[j] = '0;
      line_rank[j]  = '0;
    end
    line_count  = '0;
    cap_setting = CAP_RESET;
    for (int j = 0; j < POOL_SIZE; j++) key_pool[j] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    phase_cap[PHASES-1] = CAP_W'($urandom_range(31));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        @(posedge clk_i);
        cfg_we_i    <= 1'b1;
        cfg_wdata_i <= phase_cap[p];
        @(posedge clk_i);
        cfg_we_i    <= 1'b0;
        cap_setting = phase_cap[p];
        for (int j = 0; j < 4; j++) key_pool[$urandom_range(POOL_SIZE - 1)] = $urandom();
      end
      sender_idle_pct = phase_idle[p];
      if (p == 0) begin
        queue_req(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_req(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_req(ACT_GET, 32'h8000_0000, 32'h0000_0000);
        queue_req(ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_req(ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_req(ACT_PUT, 32'h0000_0000, 32'h0000_0000);
        queue_req(ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(ACT_GET, 32'hFFFF_FFFF, 32'h1234_5678);
        queue_req(ACT_GET, 32'h0000_0000, 32'h0000_0000);
        queue_req(ACT_PUT, 32'h7FFF_FFFF, 32'h0000_0001);
        queue_req(ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_req(ACT_GET, 32'h0000_0001, 32'h0000_0000);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        queue_req(action_e'($urandom_range(1)),
                  ($urandom_range(99) < 75) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                            : KEY_W'($urandom()),
                  VAL_W'($urandom()));
      end
    end
    wait_drained();

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
